### design/fpa_pkg.sv
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW = 32;
  localparam int NUM_W = DW + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = (DIV_STEPS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  localparam logic [3:0] FN_ADD      = 4'd0;
  localparam logic [3:0] FN_SUB      = 4'd1;
  localparam logic [3:0] FN_MUL      = 4'd2;
  localparam logic [3:0] FN_DIV      = 4'd3;
  localparam logic [3:0] FN_MIN      = 4'd4;
  localparam logic [3:0] FN_MAX      = 4'd5;
  localparam logic [3:0] FN_INC      = 4'd6;
  localparam logic [3:0] FN_DEC      = 4'd7;
  localparam logic [3:0] FN_FROM_INT = 4'd8;
  localparam logic [3:0] FN_TO_INT   = 4'd9;

  typedef struct packed {
    logic [DW-1:0] simple;
    logic          less;
    logic          equal;
    logic          greater;
    logic [3:0]    func;
    logic          div_zero;
    logic          q_neg;
    logic          p_neg;
  } side_t;

endpackage

### design/fpa_div.sv
// Unsigned restoring divider, BITS_PER_STAGE quotient bits per pipeline stage.
module fpa_div
  import fpa_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] q_r [DIV_STAGES+1];
  logic [DW:0]      r_r [DIV_STAGES+1];
  logic [DW-1:0]    d_r [DIV_STAGES+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] q_c;
    logic [DW:0]      r_c;
    logic [NUM_W-1:0] q_o;
    logic [DW:0]      r_o;
    logic [DW-1:0]    d_o;

    always_comb begin
      q_c = q_r[s];
      r_c = r_r[s];
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        if (s * BITS_PER_STAGE + k < DIV_STEPS) begin
          r_c = {r_c[DW-1:0], q_c[NUM_W-1]};
          q_c = {q_c[NUM_W-2:0], 1'b0};
          if (r_c >= {1'b0, d_r[s]}) begin
            r_c = r_c - {1'b0, d_r[s]};
            q_c[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_o <= q_c;
        r_o <= r_c;
        d_o <= d_r[s];
      end
    end

    always_comb begin
      q_r[s+1] = q_o;
      r_r[s+1] = r_o;
      d_r[s+1] = d_o;
    end
  end

  assign quo = q_r[DIV_STAGES];

endmodule

### design/fpa_mul.sv
// Unsigned product of operand magnitudes, registered as am/bm, prod, then mag for the truncating shift.
module fpa_mul
  import fpa_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [DW-1:0]     a,
  input  logic [DW-1:0]     b,
  output logic [2*DW-1:0]   mag
);

  logic [DW-1:0]     am, bm;
  logic [2*DW-1:0]   prod;

  // The product sign travels in the side channel of the top level.
  always_ff @(posedge clk) begin
    if (adv) begin
      am   <= a[DW-1] ? (~a + 1'b1) : a;
      bm   <= b[DW-1] ? (~b + 1'b1) : b;
      prod <= {{DW{1'b0}}, am} * {{DW{1'b0}}, bm};
      mag  <= prod;
    end
  end

endmodule

### design/fixed_point_alu_q24_8.sv
// fixed_point_alu_q24_8: signed Q24.8 fixed-point ALU.
// Input channel: operand_a, operand_b, func with in_valid / in_stall.
// Output channel: result, less, equal, greater, div_zero with out_valid /
// out_stall. One result transaction per input transaction, in order.
// Operations: add, sub, mul, div, min, max, inc, dec, from_int, to_int.
// Throughput: one transaction per cycle unless out_stall holds the pipe. The
// divider pipe between stage 0 and the result register sets the depth;
// every operation travels the same number of stages so order is kept.
// The divider retires four quotient bits per stage on magnitudes; signs
// are restored at the final stage. Multiply is a registered 32x32 product.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls and the last stage holds a valid result the
// whole pipe holds, bubbles included, and in_stall is raised; when the
// last stage is empty the pipe keeps advancing under out_stall. No
// transaction is lost or repeated.
module fixed_point_alu_q24_8
  import fpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] operand_a,
  input  logic signed [DW-1:0] operand_b,
  input  logic [3:0]           func,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] result,
  output logic                 less,
  output logic                 equal,
  output logic                 greater,
  output logic                 div_zero
);

  localparam int DEPTH = DIV_STAGES + 2;

  // Global advance: the pipe moves when the output slot is free or taken.
  logic adv;
  logic [DEPTH-1:0] vld;
  assign adv      = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 0: simple ops, flags, and divider operand magnitudes.
  side_t            s0;
  logic [DW-1:0]    ua, ub, am, bm;
  logic [NUM_W-1:0] num0;
  logic [DW-1:0]    den0;
  logic signed [DW-1:0] a_r, b_r;

  assign ua = operand_a;
  assign ub = operand_b;
  assign am = ua[DW-1] ? (~ua + 1'b1) : ua;
  assign bm = ub[DW-1] ? (~ub + 1'b1) : ub;

  always_comb begin
    s0 = '0;
    s0.less    = operand_a < operand_b;
    s0.equal   = operand_a == operand_b;
    s0.greater = operand_a > operand_b;
    s0.func    = func;
    s0.div_zero = (func == FN_DIV) && (ub == '0);
    s0.q_neg   = ua[DW-1] ^ ub[DW-1];
    s0.p_neg   = ua[DW-1] ^ ub[DW-1];
    case (func)
      FN_ADD:      s0.simple = ua + ub;
      FN_SUB:      s0.simple = ua - ub;
      FN_MIN:      s0.simple = (operand_a < operand_b) ? ua : ub;
      FN_MAX:      s0.simple = (operand_a > operand_b) ? ua : ub;
      FN_INC:      s0.simple = ua + 1'b1;
      FN_DEC:      s0.simple = ua - 1'b1;
      FN_FROM_INT: s0.simple = ua << FRAC_BITS;
      FN_TO_INT:   s0.simple = DW'(operand_a >>> FRAC_BITS);
      default:     s0.simple = '0;
    endcase
  end

  // Register stage 0 outputs feeding the side channel, divider and multiplier.
  side_t side [DIV_STAGES+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= s0;
      num0    <= {am, {FRAC_BITS{1'b0}}};
      den0    <= (ub == '0) ? DW'(1) : bm;
      a_r     <= operand_a;
      b_r     <= operand_b;
    end
  end

  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Divider: DIV_STAGES stages after stage 0.
  logic [NUM_W-1:0] quo;
  fpa_div u_div (
    .clk (clk),
    .adv (adv),
    .num (num0),
    .den (den0),
    .quo (quo)
  );

  // Multiplier: three stages; delay its result to line up with the divider.
  logic [2*DW-1:0] pmag;
  fpa_mul u_mul (
    .clk (clk),
    .adv (adv),
    .a   (a_r),
    .b   (b_r),
    .mag (pmag)
  );

  localparam int MUL_PAD = DIV_STAGES - 3;
  logic [DW-1:0] mres [MUL_PAD+1];
  logic [2*DW-1:0] pshift;
  assign pshift = pmag >> FRAC_BITS;
  // Sign of product known at stage 0 side (index 3 aligns with pmag).
  assign mres[0] = side[3].p_neg ? (~pshift[DW-1:0] + 1'b1) : pshift[DW-1:0];
  for (genvar j = 1; j <= MUL_PAD; j++) begin : g_mpad
    always_ff @(posedge clk) begin
      if (adv) begin
        mres[j] <= mres[j-1];
      end
    end
  end

  // Final stage: sign-restore quotient and select the result.
  localparam int LAST = DIV_STAGES;
  side_t sf;
  logic [DW-1:0] qw, res_next;
  assign sf = side[LAST];
  assign qw = sf.q_neg ? (~quo[DW-1:0] + 1'b1) : quo[DW-1:0];

  always_comb begin
    case (sf.func)
      FN_MUL:  res_next = mres[MUL_PAD];
      FN_DIV:  res_next = sf.div_zero ? '0 : qw;
      default: res_next = sf.simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result   <= res_next;
      less     <= sf.less;
      equal    <= sf.equal;
      greater  <= sf.greater;
      div_zero <= sf.div_zero;
    end
  end

  assign out_valid = vld[DEPTH-1];

endmodule

### design/fpa_checker.sv
module fpa_checker
  import fpa_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [DW-1:0] result,
  input logic          less,
  input logic          equal,
  input logic          greater,
  input logic          div_zero
);

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({less, equal, greater}))
    else $error("compare flags not exclusive");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> result == '0)
    else $error("div_zero with nonzero result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .result    (result),
  .less      (less),
  .equal     (equal),
  .greater   (greater),
  .div_zero  (div_zero)
);

### tb/fixed_point_alu_q24_8_tb.sv
`timescale 1ns / 100ps

module fixed_point_alu_q24_8_tb;
  import fpa_pkg::*;

  typedef struct packed {
    logic [DW-1:0] res;
    logic          lt;
    logic          eq;
    logic          gt;
    logic          dz;
  } alu_out_t;

  typedef struct {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [3:0]    fn;
    logic          known;   // expected value typed in below
    alu_out_t      want;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_RANDOM = 650;
  localparam logic [DW-1:0] MAXP = 32'h7fffffff;
  localparam logic [DW-1:0] MAXN = 32'h80000000;
  localparam logic [DW-1:0] ONE_FX = 32'h00000100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] operand_a = '0;
  logic signed [DW-1:0] operand_b = '0;
  logic [3:0] func = FN_ADD;
  logic in_stall, out_valid, less, equal, greater, div_zero;
  logic signed [DW-1:0] result;

  fixed_point_alu_q24_8 uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operand_a(operand_a), .operand_b(operand_b), .func(func),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .less(less), .equal(equal), .greater(greater),
    .div_zero(div_zero)
  );

  always #5 clk = ~clk;

  alu_out_t pending_results[$];
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold = 1'b0;

  // Compute the expected ALU output for one transaction.
  function automatic alu_out_t alu_predict(logic [DW-1:0] a, logic [DW-1:0] b,
                                           logic [3:0] fn);
    alu_out_t o;
    logic signed [63:0] sa, sb, tmp;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    o = '0;
    o.lt = (sa < sb);
    o.eq = (sa == sb);
    o.gt = (sa > sb);
    case (fn)
      FN_ADD: o.res = a + b;
      FN_SUB: o.res = a - b;
      FN_MUL: begin
        tmp = (sa * sb) / (64'sd1 <<< FRAC_BITS);
        o.res = tmp[31:0];
      end
      FN_DIV: begin
        if (b == '0) begin
          o.dz = 1'b1;
        end else begin
          tmp = (sa <<< FRAC_BITS) / sb;
          o.res = tmp[31:0];
        end
      end
      FN_MIN: o.res = (sa < sb) ? a : b;
      FN_MAX: o.res = (sa > sb) ? a : b;
      FN_INC: o.res = a + 1;
      FN_DEC: o.res = a - 1;
      FN_FROM_INT: o.res = a << FRAC_BITS;
      FN_TO_INT: o.res = $signed(a) >>> FRAC_BITS;
      default: o.res = '0;
    endcase
    return o;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("fixed_point_alu_q24_8_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Scoreboard: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    alu_out_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{result, less, equal, greater, div_zero};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp res=%h l=%b e=%b g=%b dz=%b, ",
                      "got res=%h l=%b e=%b g=%b dz=%b"},
                     exp_r.res, exp_r.lt, exp_r.eq, exp_r.gt, exp_r.dz,
                     got.res, got.lt, got.eq, got.gt, got.dz);
        end
      end
    end
  end

  // Offer one transaction and hold it until accepted.
  task automatic send_item(logic [DW-1:0] a, logic [DW-1:0] b, logic [3:0] fn,
                           alu_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    func <= fn;
    pending_results.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random operand: mix of extremes, small values and full-range noise.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(7))
      0: return MAXP;
      1: return MAXN;
      2: return $urandom_range(3) - 1;
      3: return $urandom_range(4096) - 2048;
      4: return {16'h0000, 8'($urandom_range(255)), 8'h00} ^ {32{$urandom_range(1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [DW-1:0] a, b;
    logic [3:0] fn;
    for (int i = 0; i < n; i++) begin
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? a : pick_operand();
      fn = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
      if (fn == FN_DIV && $urandom_range(9) == 0) b = '0;
      send_item(a, b, fn, alu_predict(a, b, fn));
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  dir_row_t directed[] = '{
    '{MAXP, 32'h1, FN_ADD, 1'b1, '{MAXN, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{MAXN, 32'h1, FN_SUB, 1'b1, '{MAXP, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{ONE_FX, '0, FN_DIV, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'0, '0, FN_DIV, 1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{MAXP, MAXP, FN_INC, 1'b1, '{MAXN, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{MAXN, MAXP, FN_DEC, 1'b1, '{MAXP, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{32'h5, 32'h0, 4'd10, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{32'h5, 32'h9, 4'd15, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{ONE_FX, ONE_FX, FN_MUL, 1'b1, '{ONE_FX, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{32'h3, '0, FN_FROM_INT, 1'b1, '{32'h300, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{32'hffffff00, '0, FN_TO_INT, 1'b1, '{32'hffffffff, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{32'hffffffff, '0, FN_TO_INT, 1'b0, '0},
    '{MAXN, MAXN, FN_MUL, 1'b0, '0},
    '{MAXP, MAXN, FN_MUL, 1'b0, '0},
    '{32'hffffff01, 32'h00000180, FN_MUL, 1'b0, '0},
    '{MAXN, 32'hffffff00, FN_DIV, 1'b0, '0},
    '{MAXP, 32'h1, FN_DIV, 1'b0, '0},
    '{32'hfffffd00, 32'h200, FN_DIV, 1'b0, '0},
    '{32'h100, 32'h300, FN_DIV, 1'b0, '0},
    '{MAXN, MAXP, FN_MIN, 1'b0, '0},
    '{MAXN, MAXP, FN_MAX, 1'b0, '0},
    '{32'h7, 32'h7, FN_MIN, 1'b0, '0},
    '{MAXP, '0, FN_FROM_INT, 1'b0, '0},
    '{MAXN, '0, FN_TO_INT, 1'b0, '0}
  };

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table; typed-in rows use their literal expectation.
    foreach (directed[i]) begin
      send_item(directed[i].a, directed[i].b, directed[i].fn,
                directed[i].known ? directed[i].want
                                  : alu_predict(directed[i].a, directed[i].b, directed[i].fn));
    end
    in_valid <= 1'b0;
    wait_drained();

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 15;
    recv_idle_pct = 47;
    random_phase(N_RANDOM / 3);
    wait_drained();   // sender pauses until all results are back

    // Long receiver hold while the sender keeps offering: fill the pipe.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        long_hold = 1'b1;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      random_phase(40);
    join
    wait_drained();

    // Swap the idle rates, then run with no idling at all.
    send_idle_pct = 47;
    recv_idle_pct = 15;
    random_phase(N_RANDOM / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(N_RANDOM / 3);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: directed extremes, all ops, zero divisor, unused codes;");
    $display("random traffic under stalls and backpressure, %0d results checked, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fixed_point_alu_q24_8_tb: PASS");
    end else begin
      $display("fixed_point_alu_q24_8_tb: FAIL");
    end
    $finish;
  end

endmodule
